### sv/mcdm_pkg.sv
// Shared widths, register indexes, sideband type and the sine generator for the
// mecanum drive mixer. It has no dependencies.
package mcdm_pkg;

  localparam int unsigned SINE_DEPTH_DEF = 1024;

  // Register indexes on the write port.
  localparam logic [1:0] REG_MAX_OUTPUT  = 2'd0;
  localparam logic [1:0] REG_INVERT_MASK = 2'd1;
  localparam logic [1:0] REG_SYNC_GROUP  = 2'd2;

  localparam int unsigned PROD_W = 33;  // Q2.14 times Q1.14 products
  localparam int unsigned W_W    = 34;  // signed wheel sums in Q28
  localparam int unsigned ABS_W  = 33;  // wheel magnitudes
  localparam int unsigned NUM_W  = 49;  // magnitude times max_output
  localparam int unsigned N_W    = 51;  // rounded dividend
  localparam int unsigned D_W    = 34;  // divisor, twice the norm
  localparam int unsigned Q_W    = 17;  // quotient bits resolved

  // Register stages from an accepted word to its result strobe.
  localparam int unsigned LATENCY = 6 + Q_W + 1;

  typedef struct packed {
    logic valid;
    logic neg;
    logic scaled;
  } div_side_t;

  // Sine of a turn fraction given in Q32, returned in Q1.14. It is only
  // evaluated at elaboration to build the tables.
  function automatic logic signed [15:0] sine_q14(longint unsigned phase_in);
    longint unsigned phase, quad, r, theta, t2, h, s, v;
    phase = phase_in & 64'hFFFF_FFFF;
    quad  = phase >> 30;
    r     = phase & 64'h3FFF_FFFF;
    if (quad[0]) r = 64'd1073741824 - r;
    theta = (r * 64'd1686629713) >> 30;
    t2    = (theta * theta) >> 30;
    h     = 64'd1073741824;
    h     = 64'd1073741824 - ((t2 * h) >> 30) / 64'd156;
    h     = 64'd1073741824 - ((t2 * h) >> 30) / 64'd110;
    h     = 64'd1073741824 - ((t2 * h) >> 30) / 64'd72;
    h     = 64'd1073741824 - ((t2 * h) >> 30) / 64'd42;
    h     = 64'd1073741824 - ((t2 * h) >> 30) / 64'd20;
    h     = 64'd1073741824 - ((t2 * h) >> 30) / 64'd6;
    s = (theta * h) >> 30;
    v = (s + 64'd32768) >> 16;
    if (quad[1]) v = -v;
    return 16'(v);
  endfunction

endpackage

### sv/mcdm_div.sv
// Pipelined restoring divider for one wheel lane, one quotient bit per stage.
// Depends on mcdm_pkg for widths and the sideband type.
module mcdm_div #(
  parameter int unsigned NW = mcdm_pkg::N_W,
  parameter int unsigned DW = mcdm_pkg::D_W,
  parameter int unsigned QW = mcdm_pkg::Q_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcdm_pkg::div_side_t side_i,
  input  logic [NW-1:0]       num_i,
  input  logic [DW-1:0]       den_i,
  output mcdm_pkg::div_side_t side_o,
  output logic [QW-1:0]       quo_o
);

  mcdm_pkg::div_side_t side_q [QW+1];
  logic [NW-1:0]       rem_q  [QW+1];
  logic [DW-1:0]       den_q  [QW+1];
  logic [QW-1:0]       quo_q  [QW+1];

  always_comb begin
    side_q[0] = side_i;
    rem_q[0]  = num_i;
    den_q[0]  = den_i;
    quo_q[0]  = '0;
  end

  for (genvar gi = 1; gi <= QW; gi++) begin : g_stage
    localparam int unsigned BIT = QW - gi;
    logic [NW-1:0] sub_w;
    logic          take_w;
    logic [QW-1:0] bit_w;
    assign sub_w  = NW'(den_q[gi-1]) << BIT;
    assign take_w = rem_q[gi-1] >= sub_w;
    assign bit_w  = QW'(take_w) << BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[gi] <= '0;
      end else begin
        side_q[gi] <= side_q[gi-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[gi] <= take_w ? rem_q[gi-1] - sub_w : rem_q[gi-1];
      den_q[gi] <= den_q[gi-1];
      quo_q[gi] <= quo_q[gi-1] | bit_w;
    end
  end

  assign side_o = side_q[QW];
  assign quo_o  = quo_q[QW];

endmodule

### sv/mecanum_cartesian_drive_mixer.sv
// Field-oriented mecanum drive mixer: heading rotation, wheel mixing, normalization.
// An accepted start passes the front stages, the divider lanes and the output register before its done strobe.
// Throughput is one word per cycle; busy_o stays low and the result side never stalls.
// Reset clears the valid bits and loads max_output 1.0, invert_mask 0, sync_group 0.
// Depends on mcdm_pkg and mcdm_div.
module mecanum_cartesian_drive_mixer #(
  parameter int unsigned SineTableDepth = mcdm_pkg::SINE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] cmd_x_i,
  input  logic signed [15:0] cmd_y_i,
  input  logic signed [15:0] cmd_rotation_i,
  input  logic [15:0]        heading_i,
  output logic               done_o,
  output logic signed [16:0] front_left_drive_o,
  output logic signed [16:0] front_right_drive_o,
  output logic signed [16:0] rear_left_drive_o,
  output logic signed [16:0] rear_right_drive_o,
  output logic [7:0]         update_group_o,
  output logic               was_scaled_o
);

  localparam int unsigned IDX_W = $clog2(SineTableDepth);
  localparam int unsigned PW    = mcdm_pkg::PROD_W;
  localparam int unsigned WW    = mcdm_pkg::W_W;
  localparam int unsigned AW    = mcdm_pkg::ABS_W;
  localparam int unsigned NMW   = mcdm_pkg::NUM_W;
  localparam int unsigned NW    = mcdm_pkg::N_W;
  localparam int unsigned DW    = mcdm_pkg::D_W;
  localparam int unsigned QW    = mcdm_pkg::Q_W;
  localparam logic [AW-1:0] ONE_Q28 = AW'(64'd268435456);

  // Configuration registers; write them only while the pipeline is empty (not enforced here).
  logic [15:0] max_output_q;
  logic [3:0]  invert_mask_q;
  logic [7:0]  sync_group_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_output_q  <= 16'd256;
      invert_mask_q <= '0;
      sync_group_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mcdm_pkg::REG_MAX_OUTPUT:  max_output_q  <= cfg_data_i;
        mcdm_pkg::REG_INVERT_MASK: invert_mask_q <= cfg_data_i[3:0];
        mcdm_pkg::REG_SYNC_GROUP:  sync_group_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The pipeline never holds, so every word is taken the cycle it is offered.
  assign busy_o = 1'b0;

  // Sine and cosine tables are built at elaboration from the exact phase of each entry.
  logic signed [15:0] sin_tab [SineTableDepth];
  logic signed [15:0] cos_tab [SineTableDepth];
  for (genvar gi = 0; gi < SineTableDepth; gi++) begin : g_tab
    localparam longint unsigned PH = (longint'(gi) << 32) / SineTableDepth;
    assign sin_tab[gi] = mcdm_pkg::sine_q14(PH);
    assign cos_tab[gi] = mcdm_pkg::sine_q14(PH + 64'h4000_0000);
  end

  // Valid bits, one per stage ahead of the divider.
  logic [5:0] vld_q;
  logic [5:0] vld_d;
  assign vld_d = {vld_q[4:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: scale the heading down to a table index, negate y.
  logic [16+IDX_W:0]   idx_prod_w;
  logic [IDX_W-1:0]    idx_q;
  logic signed [15:0]  x1_q, r1_q, x2_q, r2_q;
  logic signed [16:0]  y1_q, y2_q;

  assign idx_prod_w = heading_i * (IDX_W+1)'(SineTableDepth);

  always_ff @(posedge clk_i) begin
    idx_q <= idx_prod_w[16+IDX_W-1:16];
    x1_q  <= cmd_x_i;
    y1_q  <= -$signed({cmd_y_i[15], cmd_y_i});
    r1_q  <= cmd_rotation_i;
  end

  // Stage 2: registered table read.
  logic signed [15:0] sin_q, cos_q;
  always_ff @(posedge clk_i) begin
    sin_q <= sin_tab[idx_q];
    cos_q <= cos_tab[idx_q];
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    r2_q  <= r1_q;
  end

  // Stage 3: the four rotation products.
  logic signed [PW-1:0] xc_q, ys_q, xs_q, yc_q;
  logic signed [15:0]   r3_q;
  always_ff @(posedge clk_i) begin
    xc_q <= PW'(x2_q * cos_q);
    ys_q <= PW'(y2_q * sin_q);
    xs_q <= PW'(x2_q * sin_q);
    yc_q <= PW'(y2_q * cos_q);
    r3_q <= r2_q;
  end

  // Stage 4: rotated command and the wheel mix, all in Q28.
  logic signed [WW-1:0] xr_w, yr_w, rot_w;
  logic signed [WW-1:0] whl_q [4];
  assign xr_w  = WW'(xc_q) - WW'(ys_q);
  assign yr_w  = WW'(xs_q) + WW'(yc_q);
  assign rot_w = WW'(r3_q) <<< 14;

  always_ff @(posedge clk_i) begin
    whl_q[0] <=  xr_w + yr_w + rot_w;
    whl_q[1] <= -xr_w + yr_w - rot_w;
    whl_q[2] <= -xr_w + yr_w + rot_w;
    whl_q[3] <=  xr_w + yr_w - rot_w;
  end

  // Stage 5: magnitudes, signs and the largest magnitude through a two level tree.
  logic [AW-1:0] mag_w [4];
  logic [AW-1:0] mag_q [4];
  logic [3:0]    neg_q;
  logic [AW-1:0] m01_w, m23_w, max_q;

  for (genvar gi = 0; gi < 4; gi++) begin : g_abs
    logic signed [WW-1:0] neg_w;
    assign neg_w     = -whl_q[gi];
    assign mag_w[gi] = whl_q[gi][WW-1] ? neg_w[AW-1:0] : whl_q[gi][AW-1:0];
  end

  assign m01_w = (mag_w[0] > mag_w[1]) ? mag_w[0] : mag_w[1];
  assign m23_w = (mag_w[2] > mag_w[3]) ? mag_w[2] : mag_w[3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      mag_q[i] <= mag_w[i];
      neg_q[i] <= whl_q[i][WW-1];
    end
    max_q <= (m01_w > m23_w) ? m01_w : m23_w;
  end

  // Stage 6: dividend and divisor. Without normalization the norm is 1.0 in Q28,
  // which makes the same rounded division equal to a rounding shift by 28.
  logic          scaled_w;
  logic [AW-1:0] norm_w;
  logic [NW-1:0] num_q [4];
  logic [DW-1:0] den_q;
  logic          scaled_q;
  logic [3:0]    flip_q;

  assign scaled_w = max_q > ONE_Q28;
  assign norm_w   = scaled_w ? max_q : ONE_Q28;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      num_q[i] <= (NW'(NMW'(mag_q[i] * max_output_q)) << 1) + NW'(norm_w);
      flip_q[i] <= neg_q[i] ^ invert_mask_q[i];
    end
    den_q    <= DW'(norm_w) << 1;
    scaled_q <= scaled_w;
  end

  // Divider lanes, one per wheel.
  mcdm_pkg::div_side_t side_in  [4];
  mcdm_pkg::div_side_t side_out [4];
  logic [QW-1:0]       quo_w    [4];

  for (genvar gi = 0; gi < 4; gi++) begin : g_div
    assign side_in[gi] = '{valid: vld_q[5], neg: flip_q[gi], scaled: scaled_q};
    mcdm_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .side_i (side_in[gi]),
      .num_i  (num_q[gi]),
      .den_i  (den_q),
      .side_o (side_out[gi]),
      .quo_o  (quo_w[gi])
    );
  end

  // Output stage: clamp the magnitude, apply the sign, raise the strobe.
  logic signed [16:0] drv_w [4];
  logic signed [16:0] drv_q [4];
  logic               done_q, scaled_out_q;

  for (genvar gi = 0; gi < 4; gi++) begin : g_out
    logic [15:0] sat_w;
    assign sat_w      = quo_w[gi][QW-1:16] != '0 ? 16'hFFFF : quo_w[gi][15:0];
    assign drv_w[gi]  = side_out[gi].neg ? -$signed({1'b0, sat_w}) : $signed({1'b0, sat_w});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_out[0].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) drv_q[i] <= drv_w[i];
    scaled_out_q <= side_out[0].scaled;
  end

  assign done_o              = done_q;
  assign front_left_drive_o  = drv_q[0];
  assign front_right_drive_o = drv_q[1];
  assign rear_left_drive_o   = drv_q[2];
  assign rear_right_drive_o  = drv_q[3];
  assign update_group_o      = sync_group_q;
  assign was_scaled_o        = scaled_out_q;

endmodule

### sv/mcdm_checker.sv
// Port level checks for the mecanum drive mixer, attached by bind.
// Depends on mcdm_pkg for the pipeline latency.
module mcdm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  localparam int unsigned LAT = mcdm_pkg::LATENCY;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted word produced no result at the expected latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, LAT)) |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without a matching accepted word");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised on a fully pipelined block");

endmodule

bind mecanum_cartesian_drive_mixer mcdm_checker u_mcdm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
